[src/seg_isect_pkg.sv]
// Shared types, widths and turn codes for the segment intersection test.
`default_nettype none

package seg_isect_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int UNIT_STAGES = 4;
    localparam int STAGES     = UNIT_STAGES + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic        [PROD_BITS-1:0]  t_usq;
    typedef logic        [1:0]            t_turn;

    localparam t_turn TURN_ZERO = 2'b00;
    localparam t_turn TURN_POS  = 2'b01;
    localparam t_turn TURN_NEG  = 2'b11;

    typedef struct packed {
        logic [UNIT_STAGES-1:0] en;
    } t_pipe_ctl;

    // True when the product of two turns is zero or negative.
    function automatic logic turns_oppose(input t_turn a, input t_turn b);
        turns_oppose = (a == TURN_ZERO) || (b == TURN_ZERO) || (a != b);
    endfunction

endpackage

`default_nettype wire

[src/seg_isect_if.sv]
// Valid/ready channel interfaces for segment pairs and meet results.
`default_nettype none

interface seg_pair_if;
    import seg_isect_pkg::*;

    logic   valid;
    logic   ready;
    t_coord a_start_x;
    t_coord a_start_y;
    t_coord a_end_x;
    t_coord a_end_y;
    t_coord b_start_x;
    t_coord b_start_y;
    t_coord b_end_x;
    t_coord b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

interface seg_meet_if;
    logic valid;
    logic ready;
    logic segments_meet;

    modport source (output valid, segments_meet, input ready);
    modport sink (input valid, segments_meet, output ready);
endinterface

`default_nettype wire

[src/seg_isect_turn.sv]
// Four-stage pipelined counterclockwise-turn evaluation of three points.
`default_nettype none

module seg_isect_turn (
    input  wire                        i_clk,
    input  seg_isect_pkg::t_pipe_ctl   i_ctl,
    input  seg_isect_pkg::t_coord      i_x0,
    input  seg_isect_pkg::t_coord      i_y0,
    input  seg_isect_pkg::t_coord      i_x1,
    input  seg_isect_pkg::t_coord      i_y1,
    input  seg_isect_pkg::t_coord      i_x2,
    input  seg_isect_pkg::t_coord      i_y2,
    output seg_isect_pkg::t_turn       o_turn
);
    import seg_isect_pkg::*;

    // stage 1: differences
    t_diff r_dx1, r_dy1, r_dx2, r_dy2;
    // stage 2: products and the collinear "behind" flag
    t_prod r_c1, r_c2;
    t_usq  r_sqx1, r_sqy1, r_sqx2, r_sqy2;
    logic  r_back2;
    // stage 3: cross compare and squared lengths
    logic  r_gt, r_lt, r_back3;
    t_usq  r_len1, r_len2;
    // stage 4: turn code
    t_turn r_turn;

    t_prod n_c1, n_c2, n_sqx1, n_sqy1, n_sqx2, n_sqy2;
    logic  n_back;
    t_turn n_turn;

    always_comb begin
        n_c1   = r_dx1 * r_dy2;
        n_c2   = r_dy1 * r_dx2;
        n_sqx1 = r_dx1 * r_dx1;
        n_sqy1 = r_dy1 * r_dy1;
        n_sqx2 = r_dx2 * r_dx2;
        n_sqy2 = r_dy2 * r_dy2;
        // product of two differences is negative when signs differ and neither is zero
        n_back = ((r_dx1 < 0) && (r_dx2 > 0)) || ((r_dx1 > 0) && (r_dx2 < 0)) ||
                 ((r_dy1 < 0) && (r_dy2 > 0)) || ((r_dy1 > 0) && (r_dy2 < 0));
    end

    always_comb begin
        if (r_gt) begin
            n_turn = TURN_POS;
        end else if (r_lt) begin
            n_turn = TURN_NEG;
        end else if (r_back3) begin
            n_turn = TURN_NEG;
        end else if (r_len1 < r_len2) begin
            n_turn = TURN_POS;
        end else begin
            n_turn = TURN_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_dx1 <= t_diff'(i_x1) - t_diff'(i_x0);
            r_dy1 <= t_diff'(i_y1) - t_diff'(i_y0);
            r_dx2 <= t_diff'(i_x2) - t_diff'(i_x0);
            r_dy2 <= t_diff'(i_y2) - t_diff'(i_y0);
        end
        if (i_ctl.en[1]) begin
            r_c1    <= n_c1;
            r_c2    <= n_c2;
            r_sqx1  <= t_usq'(n_sqx1);
            r_sqy1  <= t_usq'(n_sqy1);
            r_sqx2  <= t_usq'(n_sqx2);
            r_sqy2  <= t_usq'(n_sqy2);
            r_back2 <= n_back;
        end
        if (i_ctl.en[2]) begin
            r_gt    <= r_c1 > r_c2;
            r_lt    <= r_c1 < r_c2;
            r_back3 <= r_back2;
            r_len1  <= r_sqx1 + r_sqy1;
            r_len2  <= r_sqx2 + r_sqy2;
        end
        if (i_ctl.en[3]) begin
            r_turn <= n_turn;
        end
    end

    assign o_turn = r_turn;

endmodule

`default_nettype wire

[src/segment_intersection_test.sv]
// Top level of the closed line segment intersection test.
`default_nettype none

// Takes one pair of segments per cycle and answers whether the closed
// segments share a point. A pair moves through five register stages: four
// turn units (differences, 17x17 products, compares, turn code) advance in
// lockstep and a final stage combines their turns. The result is offered from
// that final stage once it holds the pair; throughput is one pair per cycle.
// Each stage holds only while it is full and the stage after it is stalled,
// so bubbles are squeezed out and a waiting result blocks new pairs only once
// every stage is full.
module segment_intersection_test (
    input  wire          i_clk,
    input  wire          i_rst_n,
    seg_pair_if.sink     i_pair,
    seg_meet_if.source   o_meet
);
    import seg_isect_pkg::*;

    logic [STAGES-1:0] r_valid;
    logic [STAGES-1:0] en;
    t_pipe_ctl         ctl;
    t_turn             turn_a0, turn_a1, turn_b0, turn_b1;
    logic              r_meet;

    always_comb begin
        en[STAGES-1] = !r_valid[STAGES-1] || o_meet.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
        ctl.en = en[UNIT_STAGES-1:0];
    end

    assign i_pair.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[0]) begin
                r_valid[0] <= i_pair.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    seg_isect_turn u_turn_a0 (
        .i_clk (i_clk), .i_ctl (ctl),
        .i_x0 (i_pair.a_start_x), .i_y0 (i_pair.a_start_y),
        .i_x1 (i_pair.a_end_x),   .i_y1 (i_pair.a_end_y),
        .i_x2 (i_pair.b_start_x), .i_y2 (i_pair.b_start_y),
        .o_turn (turn_a0)
    );

    seg_isect_turn u_turn_a1 (
        .i_clk (i_clk), .i_ctl (ctl),
        .i_x0 (i_pair.a_start_x), .i_y0 (i_pair.a_start_y),
        .i_x1 (i_pair.a_end_x),   .i_y1 (i_pair.a_end_y),
        .i_x2 (i_pair.b_end_x),   .i_y2 (i_pair.b_end_y),
        .o_turn (turn_a1)
    );

    seg_isect_turn u_turn_b0 (
        .i_clk (i_clk), .i_ctl (ctl),
        .i_x0 (i_pair.b_start_x), .i_y0 (i_pair.b_start_y),
        .i_x1 (i_pair.b_end_x),   .i_y1 (i_pair.b_end_y),
        .i_x2 (i_pair.a_start_x), .i_y2 (i_pair.a_start_y),
        .o_turn (turn_b0)
    );

    seg_isect_turn u_turn_b1 (
        .i_clk (i_clk), .i_ctl (ctl),
        .i_x0 (i_pair.b_start_x), .i_y0 (i_pair.b_start_y),
        .i_x1 (i_pair.b_end_x),   .i_y1 (i_pair.b_end_y),
        .i_x2 (i_pair.a_end_x),   .i_y2 (i_pair.a_end_y),
        .o_turn (turn_b1)
    );

    always_ff @(posedge i_clk) begin
        if (en[STAGES-1]) begin
            r_meet <= turns_oppose(turn_a0, turn_a1) && turns_oppose(turn_b0, turn_b1);
        end
    end

    assign o_meet.valid         = r_valid[STAGES-1];
    assign o_meet.segments_meet = r_meet;

    // An empty output stage never blocks the input.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[STAGES-1] |-> i_pair.ready)
        else $error("input stalled with empty output stage");

    // A full pipeline with a stalled output takes no new pair.
    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_valid) && !o_meet.ready) |-> !i_pair.ready)
        else $error("pair accepted into a full stalled pipeline");

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_meet.valid)
        else $error("result offered right after reset");

endmodule

`default_nettype wire
